>>> sv/distributed_mutex_node_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distributed mutex node
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISTRIBUTED_MUTEX_NODE_UNIT_ASSERT_SVH
`define DISTRIBUTED_MUTEX_NODE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMX_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Types, codes, microcode table and helpers of the distributed mutex node.
// ----------------------------------------------------------------------------
package dmx_pkg;

    localparam int unsigned MAX_NODES_DEF   = 16;
    localparam int unsigned DEFER_DEPTH_DEF = 32;
    localparam int unsigned NIDX_W          = 5;

    typedef logic [31:0] stamp_t;
    typedef logic [3:0]  node_id_t;
    typedef logic [4:0]  node_cnt_t;

    localparam stamp_t STAMP_MAX = '1;

    typedef enum logic [1:0] {
        MODE_WANT    = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_REPLY   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_e;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_CRIT    = 2'd2
    } kind_e;

    typedef enum logic [0:0] {
        REG_NODE_ID    = 1'b0,
        REG_NODE_COUNT = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic [1:0] mode;
        node_id_t   sender_id;
        stamp_t     msg_stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        node_id_t   dest_id;
        stamp_t     out_stamp;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_ACCEPT = 4'd1,
        OP_WANT   = 4'd2,
        OP_BCAST  = 4'd3,
        OP_MERGE  = 4'd4,
        OP_REQ    = 4'd5,
        OP_ENTER  = 4'd6,
        OP_FLUSH  = 4'd7
    } op_e;

    typedef enum logic [2:0] {
        C_NONE      = 3'd0,
        C_DISPATCH  = 3'd1,
        C_NODE_MORE = 3'd2,
        C_NO_ENTER  = 3'd3,
        C_Q_EMPTY   = 3'd4,
        C_Q_MORE    = 3'd5
    } cond_e;

    typedef logic [3:0] upc_t;

    localparam upc_t A_IDLE      = 4'd0;
    localparam upc_t A_WANT      = 4'd1;
    localparam upc_t A_BCAST     = 4'd2;
    localparam upc_t A_REQ_MERGE = 4'd3;
    localparam upc_t A_REQ       = 4'd4;
    localparam upc_t A_RPL_MERGE = 4'd5;
    localparam upc_t A_RPL_CHECK = 4'd6;
    localparam upc_t A_ENTER     = 4'd7;
    localparam upc_t A_FLUSH     = 4'd8;

    // When cond is false the sequencer returns to idle if ret is set,
    // otherwise it steps to the next address.
    typedef struct packed {
        op_e   op;
        cond_e cond;
        upc_t  target;
        logic  ret;
    } ctrl_word_t;

    typedef struct packed {
        logic       hold;
        logic       node_more;
        logic       no_enter;
        logic       q_empty;
        logic       q_more;
        logic [1:0] mode;
    } flags_t;

    typedef struct packed {
        logic overflow;
        logic phase;
    } status_t;

    function automatic stamp_t tick(stamp_t c);
        return (c == STAMP_MAX) ? c : c + 32'd1;
    endfunction

    function automatic upc_t mode_entry(logic [1:0] mode);
        upc_t a;
        case (mode)
            MODE_WANT:    a = A_WANT;
            MODE_REQUEST: a = A_REQ_MERGE;
            MODE_REPLY:   a = A_RPL_MERGE;
            default:      a = A_IDLE;
        endcase
        return a;
    endfunction

    function automatic ctrl_word_t ucode_rom(upc_t addr);
        ctrl_word_t w;
        case (addr)
            A_IDLE:      w = '{op: OP_ACCEPT, cond: C_DISPATCH,  target: A_IDLE,  ret: 1'b0};
            A_WANT:      w = '{op: OP_WANT,   cond: C_NONE,      target: A_IDLE,  ret: 1'b0};
            A_BCAST:     w = '{op: OP_BCAST,  cond: C_NODE_MORE, target: A_BCAST, ret: 1'b1};
            A_REQ_MERGE: w = '{op: OP_MERGE,  cond: C_NONE,      target: A_IDLE,  ret: 1'b0};
            A_REQ:       w = '{op: OP_REQ,    cond: C_NONE,      target: A_IDLE,  ret: 1'b1};
            A_RPL_MERGE: w = '{op: OP_MERGE,  cond: C_NONE,      target: A_IDLE,  ret: 1'b0};
            A_RPL_CHECK: w = '{op: OP_NOP,    cond: C_NO_ENTER,  target: A_IDLE,  ret: 1'b0};
            A_ENTER:     w = '{op: OP_ENTER,  cond: C_Q_EMPTY,   target: A_IDLE,  ret: 1'b0};
            A_FLUSH:     w = '{op: OP_FLUSH,  cond: C_Q_MORE,    target: A_FLUSH, ret: 1'b1};
            default:     w = '{op: OP_NOP,    cond: C_NONE,      target: A_IDLE,  ret: 1'b1};
        endcase
        return w;
    endfunction

endpackage

>>> sv/dmx_sequencer.sv
// ----------------------------------------------------------------------------
// dmx_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module dmx_sequencer
    import dmx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  flags_t     flags,
    output ctrl_word_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    assign ctrl = ucode_rom(upc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_DISPATCH:  taken = 1'b1;
            C_NODE_MORE: taken = flags.node_more;
            C_NO_ENTER:  taken = flags.no_enter;
            C_Q_EMPTY:   taken = flags.q_empty;
            C_Q_MORE:    taken = flags.q_more;
            default:     taken = 1'b0;
        endcase

        if (flags.hold)
        begin
            upc_next = upc_reg;
        end
        else if (taken)
        begin
            upc_next = (ctrl.cond == C_DISPATCH) ? mode_entry(flags.mode) : ctrl.target;
        end
        else if (ctrl.ret)
        begin
            upc_next = A_IDLE;
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> sv/dmx_datapath.sv
// ----------------------------------------------------------------------------
// dmx_datapath
// Lamport clock, request state, deferred-reply queue and output register,
// driven one operation per cycle by the microcode control word unless a result stalls.
// ----------------------------------------------------------------------------
module dmx_datapath
    import dmx_pkg::*;
#(
    parameter int unsigned MAX_NODES   = MAX_NODES_DEF,
    parameter int unsigned DEFER_DEPTH = DEFER_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  ctrl_word_t ctrl,
    output flags_t     flags,
    output status_t    status
);

    localparam int unsigned AW = (DEFER_DEPTH > 1) ? $clog2(DEFER_DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEFER_DEPTH + 1);
    localparam logic [MAX_NODES-1:0] BIT0 = MAX_NODES'(1);

    // Configuration
    node_id_t  node_id_reg;
    node_cnt_t node_count_reg;

    // Protocol state
    stamp_t                clock_reg,     clock_next;
    logic                  phase_reg,     phase_next;
    stamp_t                req_stamp_reg, req_stamp_next;
    logic [MAX_NODES-1:0]  seen_reg,      seen_next;
    logic [CW-1:0]         count_reg,     count_next;
    logic                  ovf_reg,       ovf_next;
    logic [NIDX_W-1:0]     nidx_reg,      nidx_next;
    logic [CW-1:0]         qidx_reg,      qidx_next;
    in_item_t              in_reg;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg,  out_item_next;

    // Deferred queue
    node_id_t              mem [DEFER_DEPTH];
    node_id_t              rd_data_reg;
    logic                  q_we;

    // Working signals
    node_cnt_t             n_eff;
    logic [MAX_NODES-1:0]  need;
    logic                  all_in;
    logic                  later;
    logic [NIDX_W:0]       nidx_p1, nidx_p2, n_wide, id_wide;
    logic [CW:0]           qidx_p1;
    stamp_t                merged;
    stamp_t                ticked;
    logic                  emit;
    logic                  stall;
    out_item_t             emit_item;

    assign in_ready  = (ctrl.op == OP_ACCEPT);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign status    = '{overflow: ovf_reg, phase: phase_reg};

    assign n_eff   = (32'(node_count_reg) > MAX_NODES) ? 5'(MAX_NODES) : node_count_reg;
    assign nidx_p1 = {1'b0, nidx_reg} + 6'd1;
    assign nidx_p2 = {1'b0, nidx_reg} + 6'd2;
    assign n_wide  = {1'b0, n_eff};
    assign id_wide = {2'b00, node_id_reg};
    assign qidx_p1 = {1'b0, qidx_reg} + (CW+1)'(1);
    assign merged  = (in_reg.msg_stamp > clock_reg) ? in_reg.msg_stamp : clock_reg;
    assign ticked  = tick(clock_reg);

    // Every peer below the effective count, other than this node, must have replied.
    always_comb
    begin
        for (int j = 0; j < MAX_NODES; j++)
        begin
            need[j] = (j < int'(n_eff)) && (j != int'(node_id_reg));
        end
    end
    assign all_in = &(seen_reg | ~need);

    assign later = (in_reg.msg_stamp > req_stamp_reg) ||
                   ((in_reg.msg_stamp == req_stamp_reg) && (in_reg.sender_id > node_id_reg));

    // Result produced by the current step, if any.
    always_comb
    begin
        emit      = 1'b0;
        emit_item = '{kind: KIND_REPLY, dest_id: in_reg.sender_id, out_stamp: ticked,
                      last: 1'b1};
        case (ctrl.op)
            OP_BCAST:
            begin
                emit      = (nidx_reg < n_eff) && (nidx_reg != {1'b0, node_id_reg});
                emit_item = '{kind: KIND_REQUEST, dest_id: nidx_reg[3:0],
                              out_stamp: req_stamp_reg,
                              last: (nidx_p1 >= n_wide) ||
                                    ((nidx_p2 >= n_wide) && (nidx_p1 == id_wide))};
            end
            OP_REQ:
            begin
                emit = !(phase_reg && later);
            end
            OP_ENTER:
            begin
                emit      = 1'b1;
                emit_item = '{kind: KIND_CRIT, dest_id: node_id_reg, out_stamp: clock_reg,
                              last: (count_reg == '0)};
            end
            OP_FLUSH:
            begin
                emit      = 1'b1;
                emit_item = '{kind: KIND_REPLY, dest_id: rd_data_reg, out_stamp: ticked,
                              last: !(qidx_p1 < {1'b0, count_reg})};
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign stall = emit && out_valid_reg && !out_ready;

    assign flags = '{hold:      stall || ((ctrl.op == OP_ACCEPT) && !in_valid),
                     node_more: (nidx_p1 < n_wide),
                     no_enter:  !(phase_reg && all_in),
                     q_empty:   (count_reg == '0),
                     q_more:    (qidx_p1 < {1'b0, count_reg}),
                     mode:      in_item.mode};

    always_comb
    begin
        clock_next     = clock_reg;
        phase_next     = phase_reg;
        req_stamp_next = req_stamp_reg;
        seen_next      = seen_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        nidx_next      = nidx_reg;
        qidx_next      = qidx_reg;
        q_we           = 1'b0;

        if (!stall)
        begin
            case (ctrl.op)
                OP_WANT:
                begin
                    phase_next     = 1'b1;
                    clock_next     = ticked;
                    req_stamp_next = ticked;
                    seen_next      = BIT0 << node_id_reg;
                    nidx_next      = '0;
                end
                OP_BCAST:
                begin
                    if (emit)
                    begin
                        clock_next = ticked;
                    end
                    nidx_next = nidx_reg + NIDX_W'(1);
                end
                OP_MERGE:
                begin
                    clock_next = tick(merged);
                    // A sender beyond the bitmap shifts out and marks nothing.
                    if (in_reg.mode == MODE_REPLY)
                    begin
                        seen_next = seen_reg | (BIT0 << in_reg.sender_id);
                    end
                end
                OP_REQ:
                begin
                    if (emit)
                    begin
                        clock_next = ticked;
                    end
                    else if (32'(count_reg) < DEFER_DEPTH)
                    begin
                        q_we       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                OP_ENTER:
                begin
                    phase_next = 1'b0;
                    qidx_next  = '0;
                end
                OP_FLUSH:
                begin
                    clock_next = ticked;
                    qidx_next  = qidx_p1[CW-1:0];
                    if (emit_item.last)
                    begin
                        count_next = '0;
                    end
                end
                default:
                begin
                    clock_next = clock_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_item_next = out_item_reg;
        if (emit && !stall)
        begin
            out_valid_next = 1'b1;
            out_item_next  = emit_item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= '0;
            node_count_reg <= 5'd2;
            clock_reg      <= '0;
            phase_reg      <= 1'b0;
            req_stamp_reg  <= '0;
            seen_reg       <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            nidx_reg       <= '0;
            qidx_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_reg_e'(cfg_index))
                    REG_NODE_ID:    node_id_reg    <= cfg_data[3:0];
                    REG_NODE_COUNT: node_count_reg <= cfg_data;
                    default:        node_id_reg    <= node_id_reg;
                endcase
            end
            clock_reg     <= clock_next;
            phase_reg     <= phase_next;
            req_stamp_reg <= req_stamp_next;
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            nidx_reg      <= nidx_next;
            qidx_reg      <= qidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_item;
        end
        out_item_reg <= out_item_next;
    end

    // The read address follows the next queue index, so the entry for the
    // current flush step is already in the read register.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            mem[count_reg[AW-1:0]] <= in_reg.sender_id;
        end
        rd_data_reg <= mem[qidx_next[AW-1:0]];
    end

endmodule

>>> sv/distributed_mutex_node_unit.sv
// ----------------------------------------------------------------------------
// distributed_mutex_node_unit
// One node of a Ricart-Agrawala mutual exclusion protocol with a Lamport clock.
// ----------------------------------------------------------------------------
// Each input transfer is handled by a short microprogram, one step per cycle
// unless a result stalls, and at most one result transfer leaves per cycle
// through the output register. After the accept step, a local want runs the
// want step and a broadcast step that walks every node index below N, the
// effective node count, once (its own included), or index zero if N is zero.
// An incoming request runs a merge and a request step. An incoming reply runs a
// merge and a check step and, if it lets the node enter its critical section,
// an enter step and one flush step per queued deferred requester. An unused
// mode runs only the accept step. Each step that produces a result holds while
// the output register is occupied and the receiver is not ready. The user must
// write node id and node count only while the block is idle; the block does not
// enforce it. The deferred queue is a plain memory; it needs no reset clearing.
// ----------------------------------------------------------------------------
`include "distributed_mutex_node_unit_assert.svh"

module distributed_mutex_node_unit
    import dmx_pkg::*;
#(
    parameter int unsigned MAX_NODES   = MAX_NODES_DEF,
    parameter int unsigned DEFER_DEPTH = DEFER_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    ctrl_word_t ctrl;
    flags_t     flags;
    status_t    status;

    dmx_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    dmx_datapath #(
        .MAX_NODES   (MAX_NODES),
        .DEFER_DEPTH (DEFER_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .ctrl      (ctrl),
        .flags     (flags),
        .status    (status)
    );

    // An accepted message with a valid mode always starts a microprogram.
    `DMX_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready && (in_item.mode != MODE_NONE), !in_ready, "input accepted again before its program ran")
    `DMX_ASSERT_NEXT(a_overflow_sticky, status.overflow, status.overflow, "overflow flag cleared")
    `DMX_ASSERT_IMPLY(a_overflow_when_waiting, $rose(status.overflow), status.phase, "queue overflow while not waiting")

endmodule

>>> verif/distributed_mutex_node_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distributed_mutex_node_unit_tb
// Self-checking bench for one Ricart-Agrawala mutual exclusion node. Input
// transfers are mirrored into a Lamport clock and deferral predictor that
// keeps its own node state; every result transfer is compared field by field
// with the oldest predicted message. Directed cases come first. They are
// followed by random request rounds under several node settings, with idle
// gaps on both channels.
// ----------------------------------------------------------------------------
module distributed_mutex_node_unit_tb;
    import dmx_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_ITEMS  = 320;

    class mutex_scoreboard;
        node_id_t    my_id;
        node_cnt_t   my_count;
        stamp_t      clock_now;
        stamp_t      req_stamp;
        logic        wanting;
        logic [15:0] replies;
        node_id_t    held[DEFER_DEPTH_DEF];
        int          held_count;
        logic        overflowed;
        out_item_t   expected[$];
        int          errors;
        int          results_seen;
        int          entries;

        function new();
            my_id        = '0;
            my_count     = 5'd2;
            clock_now    = '0;
            req_stamp    = '0;
            wanting      = 1'b0;
            replies      = '0;
            held_count   = 0;
            overflowed   = 1'b0;
            errors       = 0;
            results_seen = 0;
            entries      = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [4:0] value);
            if (idx == REG_NODE_ID)
                my_id = value[3:0];
            else
                my_count = value;
        endfunction

        function stamp_t step_clock(stamp_t c);
            return (c == STAMP_MAX) ? c : c + 32'd1;
        endfunction

        function void add(kind_e k, node_id_t dest, stamp_t s);
            out_item_t r;
            r.kind      = k;
            r.dest_id   = dest;
            r.out_stamp = s;
            r.last      = 1'b0;
            expected = {expected, r};
        endfunction

        function void note_input(in_item_t it);
            int n;
            int queued_before;
            bit all_in;
            bit later;
            n = (my_count > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(my_count);
            queued_before = expected.size();
            case (it.mode)
                MODE_WANT:
                begin
                    wanting   = 1'b1;
                    clock_now = step_clock(clock_now);
                    req_stamp = clock_now;
                    replies   = '0;
                    replies[my_id] = 1'b1;
                    for (int i = 0; i < n; i++)
                    begin
                        if (i != my_id)
                        begin
                            clock_now = step_clock(clock_now);
                            add(KIND_REQUEST, node_id_t'(i), req_stamp);
                        end
                    end
                end
                MODE_REQUEST, MODE_REPLY:
                begin
                    clock_now = step_clock((it.msg_stamp > clock_now) ? it.msg_stamp : clock_now);
                    if (it.mode == MODE_REPLY)
                    begin
                        replies[it.sender_id] = 1'b1;
                        all_in = 1'b1;
                        for (int i = 0; i < n; i++)
                        begin
                            if (i != my_id && !replies[i])
                                all_in = 1'b0;
                        end
                        if (wanting && all_in)
                        begin
                            add(KIND_CRIT, my_id, clock_now);
                            wanting = 1'b0;
                            entries++;
                            for (int i = 0; i < held_count; i++)
                            begin
                                clock_now = step_clock(clock_now);
                                add(KIND_REPLY, held[i], clock_now);
                            end
                            held_count = 0;
                        end
                    end
                    else
                    begin
                        later = (it.msg_stamp > req_stamp) ||
                                (it.msg_stamp == req_stamp && it.sender_id > my_id);
                        if (wanting && later)
                        begin
                            if (held_count < DEFER_DEPTH_DEF)
                            begin
                                held[held_count] = it.sender_id;
                                held_count++;
                            end
                            else
                                overflowed = 1'b1;
                        end
                        else
                        begin
                            clock_now = step_clock(clock_now);
                            add(KIND_REPLY, it.sender_id, clock_now);
                        end
                    end
                end
                default: ;
            endcase
            if (expected.size() > queued_before)
                expected[expected.size() - 1].last = 1'b1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t oldest;
            if (expected.size() == 0)
            begin
                $display("%0t: result with none expected: kind %0d dest %0d stamp %h last %0d",
                         $time, got.kind, got.dest_id, got.out_stamp, got.last);
                errors++;
                return;
            end
            oldest = expected.pop_front();
            results_seen++;
            if (got.kind !== oldest.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $time, oldest.kind, got.kind);
                errors++;
            end
            if (got.dest_id !== oldest.dest_id)
            begin
                $display("%0t: dest_id expected %0d actual %0d",
                         $time, oldest.dest_id, got.dest_id);
                errors++;
            end
            if (got.out_stamp !== oldest.out_stamp)
            begin
                $display("%0t: out_stamp expected %h actual %h",
                         $time, oldest.out_stamp, got.out_stamp);
                errors++;
            end
            if (got.last !== oldest.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, oldest.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wen;
    logic [0:0] cfg_index;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_item;

    mutex_scoreboard sb;
    logic quiet;
    bit   wide_stamps;
    int   stim_items;

    distributed_mutex_node_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("distributed_mutex_node_unit_tb failed");
        $finish;
    end

    // The receiver stalls at random except during the quiet stretch.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= quiet || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    function automatic in_item_t make_item(logic [1:0] m, node_id_t s, stamp_t t);
        in_item_t it;
        it.mode      = m;
        it.sender_id = s;
        it.msg_stamp = t;
        return it;
    endfunction

    // A stamp close to c, or now and then an arbitrary one.
    function automatic stamp_t near_stamp(stamp_t c);
        stamp_t d;
        d = $urandom_range(6);
        if (wide_stamps && $urandom_range(3) == 0)
            return $urandom();
        if ($urandom_range(7) == 0)
            return $urandom_range(c);
        if ($urandom_range(1))
            return (c > STAMP_MAX - d) ? STAMP_MAX : c + d;
        return (c < d) ? '0 : c - d;
    endfunction

    // Peers whose reply the node still needs, in random order.
    function automatic void list_peers(ref node_id_t q[$]);
        int n;
        int j;
        node_id_t tmp;
        n = (sb.my_count > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(sb.my_count);
        q.delete();
        for (int i = 0; i < n; i++)
        begin
            if (i != sb.my_id)
                q = {q, node_id_t'(i)};
        end
        for (int i = q.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = q[i];
            q[i] = q[j];
            q[j] = tmp;
        end
    endfunction

    task automatic send_item(input in_item_t it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(it);
        if (it.mode != MODE_NONE)
            stim_items++;
        if (!quiet && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Waits until every predicted result has left and the block has gone idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(node_id_t id, logic [4:0] count);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_NODE_ID;
        cfg_data  <= {1'b0, id};
        @(posedge clk);
        cfg_index <= REG_NODE_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.set_reg(REG_NODE_ID, {1'b0, id});
        sb.set_reg(REG_NODE_COUNT, count);
    endtask

    // One request round: want, optional burst of later requests, then replies
    // from every peer mixed with foreign requests, noise and at most one restart.
    task automatic run_round(int defer_target);
        node_id_t waiting_on[$];
        int pick;
        bit restarted;
        restarted = 1'b0;
        send_item(make_item(MODE_WANT, node_id_t'($urandom_range(15)), $urandom()));
        list_peers(waiting_on);
        repeat (defer_target)
            send_item(make_item(MODE_REQUEST, node_id_t'($urandom_range(15)),
                                sb.req_stamp + $urandom_range(1, 3)));
        while (waiting_on.size() != 0)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_item(make_item(MODE_REPLY, waiting_on.pop_front(),
                                    near_stamp(sb.clock_now)));
            else if (pick < 80)
                send_item(make_item(MODE_REQUEST, node_id_t'($urandom_range(15)),
                                    near_stamp(sb.req_stamp)));
            else if (pick < 87)
                send_item(make_item(MODE_NONE, node_id_t'($urandom_range(15)), $urandom()));
            else if (pick < 97 || restarted)
                send_item(make_item(MODE_REPLY, node_id_t'($urandom_range(15)),
                                    near_stamp(sb.clock_now)));
            else
            begin
                restarted = 1'b1;
                send_item(make_item(MODE_WANT, node_id_t'($urandom_range(15)), $urandom()));
                list_peers(waiting_on);
            end
        end
        // With no peers at all, any reply lets the node in.
        if (sb.wanting)
            send_item(make_item(MODE_REPLY, node_id_t'($urandom_range(15)),
                                near_stamp(sb.clock_now)));
        repeat ($urandom_range(3))
            send_item(make_item(2'($urandom_range(1, 3)), node_id_t'($urandom_range(15)),
                                near_stamp(sb.clock_now)));
    endtask

    task automatic run_phase(bit force_overflow);
        node_cnt_t count;
        node_id_t  id;
        int        lim;
        case ($urandom_range(7))
            0: count = 5'd0;
            1: count = 5'd1;
            2: count = 5'd16;
            3: count = 5'd31;
            4: count = 5'd2;
            default: count = node_cnt_t'($urandom_range(3, 8));
        endcase
        lim = (count > 16) ? 16 : int'(count);
        id = (lim > 0 && $urandom_range(1)) ? node_id_t'($urandom_range(lim - 1)) :
                                              node_id_t'($urandom_range(15));
        settle();
        write_config(id, count);
        if (force_overflow)
            run_round(34);
        repeat ($urandom_range(1, 3))
            run_round(($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(3));
    endtask

    initial
    begin
        int base;
        int phase_no;
        sb          = new();
        quiet       <= 1'b0;
        wide_stamps = 1'b0;
        stim_items  = 0;
        rst_n       <= 1'b0;
        cfg_wen     <= 1'b0;
        cfg_index   <= REG_NODE_ID;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        in_item     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two nodes: unused mode, reply and request while released, a deferred
        // and an answered request while waiting, then entry with one flush.
        write_config(4'd0, 5'd2);
        send_item(make_item(MODE_NONE, 4'hF, STAMP_MAX));
        send_item(make_item(MODE_REPLY, 4'd1, 32'd10));
        send_item(make_item(MODE_REQUEST, 4'd1, 32'd3));
        send_item(make_item(MODE_WANT, 4'd0, '0));
        send_item(make_item(MODE_REQUEST, 4'd1, 32'd40));
        send_item(make_item(MODE_REQUEST, 4'd1, 32'd2));
        send_item(make_item(MODE_REPLY, 4'd1, '0));

        // Node count above the maximum acts as sixteen nodes.
        settle();
        write_config(4'd15, 5'd31);
        send_item(make_item(MODE_WANT, 4'd0, '0));

        // Own id outside the count, equal stamp ties both ways, and a restart.
        settle();
        write_config(4'd5, 5'd3);
        send_item(make_item(MODE_WANT, 4'd0, '0));
        send_item(make_item(MODE_REQUEST, 4'd6, sb.req_stamp));
        send_item(make_item(MODE_REQUEST, 4'd4, sb.req_stamp));
        send_item(make_item(MODE_WANT, 4'd0, '0));
        send_item(make_item(MODE_REPLY, 4'd2, 32'd1));
        send_item(make_item(MODE_REPLY, 4'd0, 32'd200));
        send_item(make_item(MODE_REPLY, 4'd1, 32'd7));

        // Node counts of one and zero: no broadcast, entry on the next reply.
        settle();
        write_config(4'd0, 5'd1);
        send_item(make_item(MODE_WANT, 4'd0, '0));
        send_item(make_item(MODE_REPLY, 4'd7, 32'd0));
        settle();
        write_config(4'd0, 5'd0);
        send_item(make_item(MODE_WANT, 4'd0, '0));
        send_item(make_item(MODE_REQUEST, 4'd9, sb.req_stamp + 32'd1));
        send_item(make_item(MODE_REPLY, 4'd3, 32'd0));

        // The random part and the closing rounds together bring the total
        // close to the intended number of input transfers.
        base = stim_items;
        phase_no = 0;
        while (stim_items - base < RANDOM_ITEMS - 110)
        begin
            if (phase_no == 3)
                quiet <= 1'b1;
            else if (phase_no == 4)
                quiet <= 1'b0;
            run_phase(phase_no == 0);
            phase_no++;
        end

        // Full range stamps last, since the clock never comes back down.
        wide_stamps = 1'b1;
        while (stim_items - base < RANDOM_ITEMS - 70)
            run_phase(1'b0);
        send_item(make_item(MODE_REPLY, node_id_t'($urandom_range(15)), STAMP_MAX - 32'd1));
        run_round(2);
        run_round(2);

        settle();
        $display("Sent %0d input transfers, checked %0d result transfers.",
                 stim_items, sb.results_seen);
        $display("Critical sections entered: %0d; deferred queue overflow %s.",
                 sb.entries, sb.overflowed ? "reached" : "not reached");
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("distributed_mutex_node_unit_tb passed");
        else
            $display("distributed_mutex_node_unit_tb failed");
        $finish;
    end

endmodule
